/* hw/rtl/ppt_pkg.sv */
// Shared constants and types for the projective point transform.
package ppt_pkg;

  localparam int W          = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = PROD_W;
  localparam int SHIFT      = W - FRAC_BITS;
  localparam int CMP_W      = MAG_W + SHIFT;
  localparam int DIV_STEPS  = W;
  localparam int DIV_LAT    = DIV_STEPS + 1;
  localparam int FRONT_LAT  = 3;
  localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT;
  localparam int ROWS       = 3;

  localparam logic [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic [ROWS-1:0][MAG_W-1:0] nmag;
    logic [MAG_W-1:0]           dmag;
    logic [ROWS-1:0]            neg;
    logic                       wzero;
  } front_t;

  typedef struct packed {
    logic [ROWS-1:0] neg;
    logic            wzero;
  } side_t;

endpackage

/* hw/rtl/ppt_front.sv */
// Matrix storage, products, row sums and sign/magnitude split.
module ppt_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          wr,
  input  logic [3:0]                    entry_index,
  input  logic signed [ppt_pkg::W-1:0]  entry_value,
  input  logic signed [ppt_pkg::W-1:0]  in_x,
  input  logic signed [ppt_pkg::W-1:0]  in_y,
  input  logic signed [ppt_pkg::W-1:0]  in_z,
  output ppt_pkg::front_t               front
);
  import ppt_pkg::*;

  logic signed [W-1:0]      mat [16];
  logic signed [PROD_W-1:0] prod [4][4];
  logic signed [SUM_W-1:0]  sum [4];
  logic signed [SUM_W-1:0]  sum_abs [4];

  always_ff @(posedge clk) begin
    if (wr) begin
      mat[entry_index] <= entry_value;
    end
  end

  // stage 1: products, column 3 multiplies the implicit 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= PROD_W'(mat[r]) * PROD_W'(in_x);
        prod[r][1] <= PROD_W'(mat[r + 4]) * PROD_W'(in_y);
        prod[r][2] <= PROD_W'(mat[r + 8]) * PROD_W'(in_z);
        prod[r][3] <= PROD_W'(mat[r + 12]) <<< FRAC_BITS;
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
                + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_abs[r] = sum[r][SUM_W-1] ? -sum[r] : sum[r];
    end
  end

  // stage 3: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < ROWS; r++) begin
        front.nmag[r] <= sum_abs[r][MAG_W-1:0];
        front.neg[r]  <= sum[r][SUM_W-1] ^ sum[3][SUM_W-1];
      end
      front.dmag  <= sum_abs[3][MAG_W-1:0];
      front.wzero <= (sum[3] == '0);
    end
  end

endmodule

/* hw/rtl/ppt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with range check.
module ppt_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ppt_pkg::MAG_W-1:0]    nmag,
  input  logic [ppt_pkg::MAG_W-1:0]    dmag,
  output logic [ppt_pkg::W-1:0]        q,
  output logic                         big
);
  import ppt_pkg::*;

  logic [MAG_W-1:0] rem  [DIV_STEPS+1];
  logic [W-1:0]     low  [DIV_STEPS+1];
  logic [W-1:0]     quo  [DIV_STEPS+1];
  logic [MAG_W-1:0] den  [DIV_STEPS+1];
  logic             ovr  [DIV_STEPS+1];

  // prep: quotient fits W bits only when nmag < dmag << SHIFT
  always_ff @(posedge clk) begin
    if (en) begin
      ovr[0] <= CMP_W'(nmag) >= {dmag, {SHIFT{1'b0}}};
      rem[0] <= nmag >> SHIFT;
      low[0] <= {nmag[SHIFT-1:0], {FRAC_BITS{1'b0}}};
      quo[0] <= '0;
      den[0] <= dmag;
    end
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           take;

    assign trial = {rem[s-1], low[s-1][W-1]};
    assign diff  = trial - {1'b0, den[s-1]};
    assign take  = trial >= {1'b0, den[s-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        low[s] <= {low[s-1][W-2:0], 1'b0};
        quo[s] <= {quo[s-1][W-2:0], take};
        den[s] <= den[s-1];
        ovr[s] <= ovr[s-1];
      end
    end
  end

  assign q   = quo[DIV_STEPS];
  assign big = ovr[DIV_STEPS];

endmodule

/* hw/rtl/projective_point_transform.sv */
// Top level: 4x4 projective point transform with perspective divide.
//
// Write words (operation 0) store one column-major Q16.16 matrix entry at the
// edge they are accepted and give no result. Transform words (operation 1)
// multiply (x, y, z, 1) by the matrix and divide x, y, z by w. One word is
// accepted every cycle unless a stalled result holds the pipeline. The word
// passes 3 stages of multiply, sum and magnitude (the first loaded at the
// accepting edge), one range-check stage and 32 restoring divider stages (one
// quotient bit each, three dividers in parallel), then the output register. A
// stalled result freezes the whole pipeline while a transform waits at its end.
// A transform sees every write accepted before it. w of zero gives divide_fault
// and zero coordinates; coordinates out of range saturate and raise overflow.
module projective_point_transform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [3:0]                    entry_index,
  input  logic signed [ppt_pkg::W-1:0]  entry_value,
  input  logic signed [ppt_pkg::W-1:0]  in_x,
  input  logic signed [ppt_pkg::W-1:0]  in_y,
  input  logic signed [ppt_pkg::W-1:0]  in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ppt_pkg::W-1:0]  out_x,
  output logic signed [ppt_pkg::W-1:0]  out_y,
  output logic signed [ppt_pkg::W-1:0]  out_z,
  output logic                          divide_fault,
  output logic                          overflow
);
  import ppt_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;
  logic                  out_load;
  logic                  wr;
  front_t                front;
  side_t                 side [DIV_LAT];
  logic [W-1:0]          q   [ROWS];
  logic                  big [ROWS];
  logic [W-1:0]          res [ROWS];
  logic [W-1:0]          res_next [ROWS];
  logic [ROWS-1:0]       sat;

  assign out_load = vld[PIPE_DEPTH-1] && (!out_valid || out_ready);
  assign en       = !vld[PIPE_DEPTH-1] || out_load;
  assign in_ready = en;
  assign wr       = in_valid && in_ready && (operation == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid && (operation == OP_XFORM)};
    end
  end

  ppt_front u_front (
    .clk         (clk),
    .en          (en),
    .wr          (wr),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .front       (front)
  );

  for (genvar r = 0; r < ROWS; r++) begin : g_div
    ppt_div u_div (
      .clk  (clk),
      .en   (en),
      .nmag (front.nmag[r]),
      .dmag (front.dmag),
      .q    (q[r]),
      .big  (big[r])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].neg   <= front.neg;
      side[0].wzero <= front.wzero;
      for (int k = 1; k < DIV_LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      if (side[DIV_LAT-1].neg[r]) begin
        sat[r]      = big[r] || (q[r][W-1] && (|q[r][W-2:0]));
        res_next[r] = sat[r] ? SAT_NEG : -q[r];
      end else begin
        sat[r]      = big[r] || q[r][W-1];
        res_next[r] = sat[r] ? SAT_POS : q[r];
      end
      if (side[DIV_LAT-1].wzero) begin
        res_next[r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int r = 0; r < ROWS; r++) begin
        res[r] <= res_next[r];
      end
      divide_fault <= side[DIV_LAT-1].wzero;
      overflow     <= !side[DIV_LAT-1].wzero && (|sat);
    end
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

endmodule

/* hw/rtl/ppt_checker.sv */
// Port-level checks for the projective point transform, bound to the top.
module ppt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [ppt_pkg::W-1:0]  out_x,
  input  logic signed [ppt_pkg::W-1:0]  out_y,
  input  logic signed [ppt_pkg::W-1:0]  out_z,
  input  logic                          divide_fault,
  input  logic                          overflow
);
  import ppt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(divide_fault) && $stable(overflow))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_fault |-> out_x == '0 && out_y == '0 && out_z == '0 && !overflow)
    else $error("zero w word carries data");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      out_x == SAT_POS || out_x == SAT_NEG || out_y == SAT_POS || out_y == SAT_NEG
      || out_z == SAT_POS || out_z == SAT_NEG)
    else $error("overflow without a saturated coordinate");

endmodule

bind projective_point_transform ppt_checker u_ppt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_x        (out_x),
  .out_y        (out_y),
  .out_z        (out_z),
  .divide_fault (divide_fault),
  .overflow     (overflow)
);

/* test/tb_projective_point_transform.sv */
// Testbench for projective_point_transform: matrix writes, transforms, stalls.
module tb_projective_point_transform;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] z;
    logic         fault;
    logic         ovf;
  } point_result_t;

  logic clk, rst;
  logic in_valid, in_ready, operation;
  logic [3:0] entry_index;
  logic signed [W-1:0] entry_value, in_x, in_y, in_z;
  logic out_valid, out_ready;
  logic signed [W-1:0] out_x, out_y, out_z;
  logic divide_fault, overflow;

  logic signed [W-1:0] matrix_model [16];
  point_result_t pending_points[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_on = 1;
  int rx_hold = 0;

  projective_point_transform i_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("FAIL projective_point_transform");
      $finish;
    end
  end

  task automatic report(string what, logic [W-1:0] got, logic [W-1:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  function automatic logic signed [127:0] row_total(int r, logic signed [W-1:0] x,
                                                     logic signed [W-1:0] y,
                                                     logic signed [W-1:0] z);
    logic signed [127:0] a, b, c, d, xx, yy, zz;
    a = matrix_model[r]; b = matrix_model[r+4];
    c = matrix_model[r+8]; d = matrix_model[r+12];
    xx = x; yy = y; zz = z;
    return a * xx + b * yy + c * zz + (d <<< FRAC_BITS);
  endfunction

  function automatic point_result_t project_point(logic signed [W-1:0] x,
                                                  logic signed [W-1:0] y,
                                                  logic signed [W-1:0] z);
    point_result_t res;
    logic signed [127:0] wsum, num;
    logic [127:0] nmag, dmag, q;
    logic neg;
    logic [W-1:0] coord [3];
    res = '{default: 0};
    wsum = row_total(3, x, y, z);
    if (wsum == 0) begin
      res.fault = 1;
      return res;
    end
    dmag = wsum < 0 ? -wsum : wsum;
    for (int r = 0; r < 3; r++) begin
      num = row_total(r, x, y, z);
      nmag = num < 0 ? -num : num;
      neg = (num < 0) != (wsum < 0);
      q = (nmag << FRAC_BITS) / dmag;
      if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
        coord[r] = neg ? SAT_NEG : SAT_POS;
        res.ovf = 1;
      end else begin
        coord[r] = neg ? -q[W-1:0] : q[W-1:0];
      end
    end
    res.x = coord[0]; res.y = coord[1]; res.z = coord[2];
    return res;
  endfunction

  task automatic send_word(op_t op, logic [3:0] idx, logic [W-1:0] val,
                           logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    bit taken;
    in_valid <= 1; operation <= op; entry_index <= idx; entry_value <= val;
    in_x <= x; in_y <= y; in_z <= z;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (op == OP_WRITE) matrix_model[idx] = val;
    else pending_points.push_back(project_point(x, y, z));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    endcase
  endfunction

  task automatic write_matrix(bit rand_vals, logic [W-1:0] diag);
    for (int i = 0; i < 16; i++)
      send_word(OP_WRITE, 4'(i), rand_vals ? pick_value() : ((i % 5 == 0) ? diag : 0),
                $urandom, $urandom, $urandom);
  endtask

  task automatic random_xform();
    send_word(OP_XFORM, 4'($urandom), $urandom, pick_value(), pick_value(), pick_value());
  endtask

  task automatic test_identity();
    logic [W-1:0] vals [5] = '{0, 1, SAT_POS, SAT_NEG, 32'h10000};
    write_matrix(0, 32'h10000);
    foreach (vals[i]) send_word(OP_XFORM, 4'hF, SAT_NEG, vals[i], vals[(i+1)%5], vals[(i+2)%5]);
  endtask

  task automatic test_zero_w();
    send_word(OP_WRITE, 15, 0, 0, 0, 0);
    send_word(OP_XFORM, 0, 0, 32'h30000, SAT_NEG, 5);
    send_word(OP_XFORM, 0, 0, 0, 0, 0);
  endtask

  task automatic test_saturation();
    send_word(OP_WRITE, 15, 1, 0, 0, 0);
    send_word(OP_XFORM, 0, 0, SAT_POS, SAT_NEG, SAT_POS);
    send_word(OP_WRITE, 15, SAT_NEG, 0, 0, 0);
    send_word(OP_XFORM, 0, 0, SAT_NEG, SAT_POS, 1);
    send_word(OP_XFORM, 0, 0, 32'h8000, 32'hFFFF8000, 0);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 40) == 0) write_matrix(1, 0);
      else if ($urandom_range(0, 3) == 0)
        send_word(OP_WRITE, 4'($urandom), pick_value(), $urandom, $urandom, $urandom);
      else random_xform();
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    for (int k = 0; k < 80; k++) random_xform();
    in_valid <= 0;
    wait (pending_points.size() == 0);
    @(posedge clk);
  endtask

  // receiver: out_ready bursts and long holds
  initial begin
    int gap;
    gap = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 0;
        rx_hold--;
      end else if (gap > 0) begin
        out_ready <= 0;
        gap--;
      end else begin
        out_ready <= 1;
        if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);
      end
    end
  end

  // result checker
  initial begin
    bit hit;
    point_result_t got, exp;
    forever begin
      @(negedge clk);
      hit = out_valid && out_ready && !rst;
      got = '{out_x, out_y, out_z, divide_fault, overflow};
      @(posedge clk);
      if (hit) begin
        if (pending_points.size() == 0) begin
          report("unexpected word", got.x, '0);
        end else begin
          exp = pending_points.pop_front();
          if (got.x !== exp.x) report("out_x", got.x, exp.x);
          if (got.y !== exp.y) report("out_y", got.y, exp.y);
          if (got.z !== exp.z) report("out_z", got.z, exp.z);
          if (got.fault !== exp.fault) report("divide_fault", W'(got.fault), W'(exp.fault));
          if (got.ovf !== exp.ovf) report("overflow", W'(got.ovf), W'(exp.ovf));
        end
      end
    end
  end

  initial begin
    rst = 1; in_valid = 0; operation = 0; entry_index = 0; entry_value = 0;
    in_x = 0; in_y = 0; in_z = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_identity();
    test_zero_w();
    test_saturation();
    test_random(170);
    test_backpressure();
    test_random(100);
    idle_on = 0;
    test_random(55);
    in_valid <= 0;
    wait (pending_points.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_points.size() == 0) $display("PASS projective_point_transform");
    else $display("FAIL projective_point_transform");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_front.sv
hw/rtl/ppt_div.sv
hw/rtl/projective_point_transform.sv
hw/rtl/ppt_checker.sv
test/tb_projective_point_transform.sv
